FILE: hdl/pnfs_pkg.sv
// pnfs_pkg: shared constants, command and register codes, sequencer states
// and fixed-point helpers for the particle neighbor force step unit
// no dependencies
package pnfs_pkg;

    localparam int NUM_TYPES = 8;
    localparam int PAIRS     = NUM_TYPES * NUM_TYPES;
    localparam int PAIR_AW   = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int MASS_AW   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int TYPE_W    = 3;

    localparam int IN_W       = 200;
    localparam int USER_W     = 3;
    localparam int OUT_W      = 80;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int MUL_W     = 34;
    localparam int DVD_W     = 64;
    localparam int DVS_W     = 34;
    localparam int PAIR_W    = 80;

    localparam logic [2:0] CMD_LOAD     = 3'd0;
    localparam logic [2:0] CMD_NEIGHBOR = 3'd1;
    localparam logic [2:0] CMD_FINISH   = 3'd2;
    localparam logic [2:0] CMD_PAIR_WR  = 3'd3;
    localparam logic [2:0] CMD_MASS_WR  = 3'd4;

    localparam logic [2:0] CFG_STEP_SCALE   = 3'd0;
    localparam logic [2:0] CFG_FRICTION     = 3'd1;
    localparam logic [2:0] CFG_DAMPING      = 3'd2;
    localparam logic [2:0] CFG_REPULSE_MULT = 3'd3;
    localparam logic [2:0] CFG_PLANE_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_PLANE_HEIGHT = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE, ST_READ, ST_SQX, ST_SQY, ST_RCMP, ST_ROOT, ST_FORCE, ST_REPK,
        ST_PDIV, ST_PWAIT, ST_RMUL, ST_RDIV, ST_RWAIT, ST_FSUM, ST_DAMP, ST_ACC,
        ST_AWAIT, ST_MOVE, ST_MOVS, ST_XMUL, ST_XDIV, ST_XWAIT, ST_YMUL, ST_YDIV,
        ST_YWAIT, ST_FRIC, ST_FRICS
    } state_t;

    function automatic logic type_ok(input logic [TYPE_W-1:0] t);
        return {4'b0, t} < 7'(NUM_TYPES);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // shift right rounding toward zero
    function automatic logic signed [63:0] tdiv_pow2(input logic signed [63:0] v,
                                                    input int sh);
        logic signed [63:0] bias;
        bias = (v < 0) ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
        return (v + bias) >>> sh;
    endfunction

endpackage

FILE: hdl/pnfs_ram.sv
// pnfs_ram: generic single-write, single-read synchronous memory
// registered read data; no dependencies
module pnfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/pnfs_sqrt.sv
// pnfs_sqrt: floor square root of a 64-bit value, two bits per cycle
// 32 iterations; uses pnfs_pkg
module pnfs_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);
    import pnfs_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= value;
            r_reg   <= '0;
            bit_reg <= 64'd1 << 62;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];
endmodule

FILE: hdl/pnfs_div.sv
// pnfs_div: signed divider, quotient truncated toward zero, one bit per cycle
// 64 iterations; uses pnfs_pkg
module pnfs_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [pnfs_pkg::DVD_W-1:0] dividend,
    input  logic signed [pnfs_pkg::DVS_W-1:0] divisor,
    output logic                              busy,
    output logic                              done,
    output logic signed [pnfs_pkg::DVD_W-1:0] quotient
);
    import pnfs_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic             neg_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
            dvs_reg <= divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
            quo_reg <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? DVS_W'(shifted - {1'b0, dvs_reg}) : shifted[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);
endmodule

FILE: hdl/particle_neighbor_force_step_unit.sv
// Particle neighbor force step unit. Load, finish, pair-table and mass-table words
// are handled in the idle state, as is a neighbor word that is skipped or whose type
// is out of range. One outside the pair radius passes the read, squaring and compare
// states; one inside also uses the one-bit-per-cycle divider (up to five divisions of
// 64 steps each), the 32-step square root and a single shared 34x34 multiplier. The
// pair tables (radius, min distance, force) share one memory and the masses another;
// their entries hold nothing meaningful until written. A finish word waits while a
// previous result is still unread, unless that result is taken in the same cycle.
// top level; uses pnfs_pkg, pnfs_ram, pnfs_sqrt, pnfs_div
module particle_neighbor_force_step_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x, pos_y, velocity_in, particle_type, other_type, skip_self,
    // pair_radius, pair_min_dist, pair_force, type_mass, zero pad
    input  logic [pnfs_pkg::IN_W-1:0]           s_tdata,
    // command
    input  logic [pnfs_pkg::USER_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // new_x, new_y, velocity_out
    output logic [pnfs_pkg::OUT_W-1:0]          m_tdata,
    input  logic                                cfg_we,
    input  logic [pnfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pnfs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import pnfs_pkg::*;

    // configuration
    logic [23:0] step_scale_reg, damping_reg, width_reg, height_reg;
    logic [15:0] friction_reg, repulse_reg;

    // particle state
    logic [23:0]        self_x_reg, self_y_reg;
    logic signed [31:0] accum_x_reg, accum_y_reg, speed_reg;
    logic [2:0]         self_kind_reg;

    // input fields
    logic [2:0]         in_cmd;
    logic [23:0]        in_x, in_y, in_rad, in_mind;
    logic [31:0]        in_vel, in_force, in_mass;
    logic [2:0]         in_a, in_b;
    logic               in_skip, in_acc;

    assign in_cmd   = s_tuser[2:0];
    assign in_x     = s_tdata[23:0];
    assign in_y     = s_tdata[47:24];
    assign in_vel   = s_tdata[79:48];
    assign in_a     = s_tdata[82:80];
    assign in_b     = s_tdata[85:83];
    assign in_skip  = s_tdata[86];
    assign in_rad   = s_tdata[110:87];
    assign in_mind  = s_tdata[134:111];
    assign in_force = s_tdata[166:135];
    assign in_mass  = s_tdata[198:167];
    assign in_acc   = s_tvalid && s_tready;

    state_t state_reg, state_next;

    // datapath registers
    logic signed [26:0]       dx_reg, dy_reg;
    logic [23:0]              rad_reg, mind_reg;
    logic signed [31:0]       f_reg, fd_reg, move_reg;
    logic [31:0]              mass_reg;
    logic [63:0]              d2_reg;
    logic [25:0]              len_reg;
    logic signed [63:0]       prim_reg, rep_reg;
    logic signed [2*MUL_W-1:0] prod_reg;
    logic signed [63:0]       prod;
    logic                     m_valid_reg;
    logic [OUT_W-1:0]         out_reg;

    // shared units
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic                    div_start, div_busy, div_done;
    logic signed [DVD_W-1:0] div_dvd, div_q;
    logic signed [DVS_W-1:0] div_dvs;
    logic                    sqrt_start, sqrt_done;
    logic [31:0]             sqrt_root;

    // memories
    logic                pair_we, mass_we;
    logic [PAIR_AW-1:0]  pair_waddr, pair_raddr;
    logic [MASS_AW-1:0]  mass_waddr, mass_raddr;
    logic [PAIR_W-1:0]   pair_rdata;
    logic [31:0]         mass_rdata;

    // force geometry
    logic signed [27:0] d_v, h_v, m_v, den_v, num_v;
    logic               up_v, nb_go;

    // wrapped offsets of the incoming neighbor
    logic signed [26:0] off_x, off_y;

    function automatic logic signed [26:0] wrap_off(input logic [23:0] p, input logic [23:0] s,
                                                   input logic [23:0] size);
        logic signed [26:0] d;
        logic signed [26:0] sz;
        d  = signed'({3'b0, p}) - signed'({3'b0, s});
        sz = signed'({3'b0, size});
        if ((d <<< 1) > sz) begin
            return d - sz;
        end else if ((d <<< 1) < -sz) begin
            return d + sz;
        end
        return d;
    endfunction

    function automatic logic [23:0] wrap_final(input logic [23:0] s,
                                              input logic signed [31:0] acc,
                                              input logic [23:0] size);
        logic signed [33:0] p;
        logic signed [33:0] sz;
        sz = signed'({10'b0, size});
        p  = signed'({10'b0, s}) + 34'(acc);
        if (p < 0) begin
            p = p + sz;
        end else if (p > sz) begin
            p = p - sz;
        end
        if (p < 0) begin
            return 24'd0;
        end else if (p > 34'sd16777215) begin
            return 24'hffffff;
        end
        return p[23:0];
    endfunction

    assign off_x = wrap_off(in_x, self_x_reg, width_reg);
    assign off_y = wrap_off(in_y, self_y_reg, height_reg);
    assign nb_go = in_acc && in_cmd == CMD_NEIGHBOR && !in_skip
                   && type_ok(self_kind_reg) && type_ok(in_b);

    assign prod  = prod_reg[63:0];
    assign d_v   = signed'({1'b0, len_reg, 1'b0});
    assign h_v   = signed'({4'b0, rad_reg});
    assign m_v   = signed'({3'b0, mind_reg, 1'b0});
    assign den_v = h_v - m_v;
    assign num_v = (d_v < h_v) ? (d_v - m_v) : ((h_v <<< 1) - m_v - d_v);
    assign up_v  = (f_reg > 0 && den_v > 0) || (f_reg < 0 && den_v < 0);

    // memory ports
    assign pair_we    = in_acc && in_cmd == CMD_PAIR_WR && type_ok(in_a) && type_ok(in_b);
    assign pair_waddr = PAIR_AW'(int'(in_a) * NUM_TYPES + int'(in_b));
    assign pair_raddr = PAIR_AW'(int'(self_kind_reg) * NUM_TYPES + int'(in_b));
    assign mass_we    = in_acc && in_cmd == CMD_MASS_WR && type_ok(in_a);
    assign mass_waddr = MASS_AW'(in_a);
    assign mass_raddr = MASS_AW'(self_kind_reg);

    pnfs_ram #(.WIDTH(PAIR_W), .DEPTH(PAIRS)) u_pair_ram (
        .aclk  (aclk),
        .we    (pair_we),
        .waddr (pair_waddr),
        .wdata ({in_force, in_mind, in_rad}),
        .raddr (pair_raddr),
        .rdata (pair_rdata)
    );

    pnfs_ram #(.WIDTH(32), .DEPTH(NUM_TYPES)) u_mass_ram (
        .aclk  (aclk),
        .we    (mass_we),
        .waddr (mass_waddr),
        .wdata (in_mass),
        .raddr (mass_raddr),
        .rdata (mass_rdata)
    );

    pnfs_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   (d2_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    pnfs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (nb_go) state_next = ST_READ;
            ST_READ:  state_next = ST_SQX;
            ST_SQX:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_RCMP;
            ST_RCMP:  state_next = (d2_reg > 64'(prod)) ? ST_IDLE : ST_ROOT;
            ST_ROOT:  if (sqrt_done) state_next = ST_FORCE;
            ST_FORCE: state_next = (d_v == h_v) ? ST_DAMP : ST_REPK;
            ST_REPK:  state_next = ST_PDIV;
            ST_PDIV:  state_next = (den_v != 0) ? ST_PWAIT : ST_RMUL;
            ST_PWAIT: if (div_done) state_next = ST_RMUL;
            ST_RMUL:  state_next = ST_RDIV;
            ST_RDIV:  state_next = (m_v != 0 && d_v <= m_v) ? ST_RWAIT : ST_FSUM;
            ST_RWAIT: if (div_done) state_next = ST_FSUM;
            ST_FSUM:  state_next = ST_DAMP;
            ST_DAMP:  state_next = ST_ACC;
            ST_ACC:   state_next = (mass_reg != 0) ? ST_AWAIT : ST_MOVE;
            ST_AWAIT: if (div_done) state_next = ST_MOVE;
            ST_MOVE:  state_next = ST_MOVS;
            ST_MOVS:  state_next = (len_reg != 0) ? ST_XMUL : ST_FRIC;
            ST_XMUL:  state_next = ST_XDIV;
            ST_XDIV:  state_next = ST_XWAIT;
            ST_XWAIT: if (div_done) state_next = ST_YMUL;
            ST_YMUL:  state_next = ST_YDIV;
            ST_YDIV:  state_next = ST_YWAIT;
            ST_YWAIT: if (div_done) state_next = ST_FRIC;
            ST_FRIC:  state_next = ST_FRICS;
            ST_FRICS: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // unit controls and operands
    always_comb begin
        s_tready   = state_reg == ST_IDLE
                     && (in_cmd != CMD_FINISH || !m_valid_reg || m_tready);
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_dvd    = prod;
        div_dvs    = '0;
        sqrt_start = 1'b0;
        case (state_reg)
            ST_READ: begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(dx_reg);
            end
            ST_SQX: begin
                mul_a = MUL_W'(dy_reg);
                mul_b = MUL_W'(dy_reg);
            end
            ST_SQY: begin
                mul_a = signed'(MUL_W'(rad_reg));
                mul_b = signed'(MUL_W'(rad_reg));
            end
            ST_RCMP: sqrt_start = !(d2_reg > 64'(prod));
            ST_FORCE: begin
                mul_a = (f_reg < 0) ? -MUL_W'(f_reg) : MUL_W'(f_reg);
                mul_b = signed'(MUL_W'(repulse_reg));
            end
            ST_REPK: begin
                mul_a = MUL_W'(f_reg);
                mul_b = MUL_W'(num_v);
            end
            ST_PDIV: begin
                div_start = den_v != 0;
                div_dvs   = DVS_W'(den_v);
            end
            ST_RMUL: begin
                mul_a = rep_reg[MUL_W-1:0];
                mul_b = MUL_W'(m_v - d_v);
            end
            ST_RDIV: begin
                div_start = m_v != 0 && d_v <= m_v;
                div_dvs   = DVS_W'(m_v);
            end
            ST_DAMP: begin
                mul_a = MUL_W'(fd_reg);
                mul_b = signed'(MUL_W'(damping_reg));
            end
            ST_ACC: begin
                div_start = mass_reg != 0;
                div_dvd   = tdiv_pow2(prod, 16) <<< 16;
                div_dvs   = signed'(DVS_W'(mass_reg));
            end
            ST_MOVE: begin
                mul_a = MUL_W'(speed_reg);
                mul_b = signed'(MUL_W'(step_scale_reg));
            end
            ST_XMUL: begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(move_reg);
            end
            ST_XDIV, ST_YDIV: begin
                div_start = 1'b1;
                div_dvs   = signed'(DVS_W'(len_reg));
            end
            ST_YMUL: begin
                mul_a = MUL_W'(dy_reg);
                mul_b = MUL_W'(move_reg);
            end
            ST_FRIC: begin
                mul_a = MUL_W'(speed_reg);
                mul_b = signed'(MUL_W'(friction_reg));
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // control and particle state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_scale_reg <= 24'd256;
            friction_reg   <= 16'd65535;
            damping_reg    <= 24'd65536;
            repulse_reg    <= 16'd512;
            width_reg      <= 24'd262144;
            height_reg     <= 24'd262144;
            self_x_reg     <= '0;
            self_y_reg     <= '0;
            accum_x_reg    <= '0;
            accum_y_reg    <= '0;
            speed_reg      <= '0;
            self_kind_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_STEP_SCALE:   step_scale_reg <= cfg_wdata;
                    CFG_FRICTION:     friction_reg   <= cfg_wdata[15:0];
                    CFG_DAMPING:      damping_reg    <= cfg_wdata;
                    CFG_REPULSE_MULT: repulse_reg    <= cfg_wdata[15:0];
                    CFG_PLANE_WIDTH:  width_reg      <= cfg_wdata;
                    CFG_PLANE_HEIGHT: height_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tready && !(in_acc && in_cmd == CMD_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            if (in_acc) begin
                case (in_cmd)
                    CMD_LOAD: begin
                        self_x_reg    <= in_x;
                        self_y_reg    <= in_y;
                        speed_reg     <= signed'(in_vel);
                        self_kind_reg <= in_a;
                        accum_x_reg   <= '0;
                        accum_y_reg   <= '0;
                    end
                    CMD_FINISH: begin
                        self_x_reg  <= wrap_final(self_x_reg, accum_x_reg, width_reg);
                        self_y_reg  <= wrap_final(self_y_reg, accum_y_reg, height_reg);
                        accum_x_reg <= '0;
                        accum_y_reg <= '0;
                        m_valid_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            case (state_reg)
                ST_AWAIT: if (div_done) speed_reg <= sat32(64'(speed_reg) + div_q);
                ST_XWAIT: if (div_done) accum_x_reg <= sat32(64'(accum_x_reg) + div_q);
                ST_YWAIT: if (div_done) accum_y_reg <= sat32(64'(accum_y_reg) + div_q);
                ST_FRICS: speed_reg <= 32'(tdiv_pow2(prod, 16));
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_acc && in_cmd == CMD_FINISH) begin
            out_reg <= {speed_reg,
                        wrap_final(self_y_reg, accum_y_reg, height_reg),
                        wrap_final(self_x_reg, accum_x_reg, width_reg)};
        end
        if (nb_go) begin
            dx_reg <= off_x;
            dy_reg <= off_y;
        end
        case (state_reg)
            ST_READ: begin
                rad_reg  <= pair_rdata[23:0];
                mind_reg <= pair_rdata[47:24];
                f_reg    <= signed'(pair_rdata[79:48]);
                mass_reg <= mass_rdata;
            end
            ST_SQX:   d2_reg <= 64'(prod);
            ST_SQY:   d2_reg <= d2_reg + 64'(prod);
            ST_ROOT:  if (sqrt_done) len_reg <= sqrt_root[25:0];
            ST_FORCE: begin
                fd_reg   <= f_reg;
                prim_reg <= '0;
                rep_reg  <= '0;
            end
            ST_REPK: begin
                rep_reg <= ((prod >>> 8) > 64'sd2147483648) ? -64'sd2147483648
                                                            : -(prod >>> 8);
            end
            ST_PWAIT: begin
                if (div_done) begin
                    if (up_v) begin
                        prim_reg <= (div_q > 0) ? div_q : 64'sd0;
                    end else begin
                        prim_reg <= (div_q < 0) ? div_q : 64'sd0;
                    end
                end
            end
            ST_RDIV:  if (!(m_v != 0 && d_v <= m_v)) rep_reg <= '0;
            ST_RWAIT: if (div_done) rep_reg <= div_q;
            ST_FSUM:  fd_reg <= sat32(prim_reg + rep_reg);
            ST_MOVS:  move_reg <= 32'(tdiv_pow2(prod, 24));
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_PWAIT || state_reg == ST_RWAIT ||
                      state_reg == ST_AWAIT || state_reg == ST_XWAIT ||
                      state_reg == ST_YWAIT))
        else $error("quotient arrived outside a wait state");

    a_sqrt_done_root: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> state_reg == ST_ROOT)
        else $error("root arrived outside its wait state");

    a_out_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_acc && in_cmd == CMD_FINISH))
        else $error("result without a finish word");
endmodule
